// File: src/zpcorr_pkg.sv
// shared constants, codes and types for the zero-padded 2d correlation block
package zpcorr_pkg;

  localparam int IMG_DIM     = 128;
  localparam int IMG_AW      = $clog2(IMG_DIM);
  localparam int CRD_W       = IMG_AW + 2;
  localparam int IMG_DEPTH   = IMG_DIM * IMG_DIM;
  localparam int MAX_FILTER  = 7;
  localparam int FILT_DEPTH  = MAX_FILTER * MAX_FILTER;
  localparam int FILT_AW     = $clog2(FILT_DEPTH);
  localparam int SIZE_W      = 3;
  localparam int TAP_IDX_W   = 3;
  localparam int PIX_W       = 8;
  localparam int COEF_W      = 16;
  localparam int PROD_W      = COEF_W + PIX_W + 1;
  localparam int ACC_W       = 32;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(3);

  typedef enum logic [CMD_W-1:0] {
    CMD_PIXEL = 2'd0,
    CMD_TAP   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DONE
  } state_t;

endpackage

// File: src/zero_padded_2d_correlation_top.sv
// zero-padded 2d correlation: image and filter stores with one shared multiply-accumulate
//
// in_* channel: one item per handshake; in_tuser selects what the item does.
//   pixel load and tap load are written in the cycle they are accepted, no result.
//   a query walks the n x n window (n = filter_size) one tap per cycle through
//   one multiplier and one accumulator, counting taps that fall outside the image as zero.
// out_* channel: one item per query with the sum and the queried coordinate.
// cfg_* channel: filter_size, always ready; write only while the block is idle.
// a query: each tap goes through the one read port of each store, the product register
//   and the accumulator, and the sum is then loaded into the output register (at once
//   when n = 0); the block takes no new item until the sum is loaded.
// loads do not hold the input: in_tready stays high after one is taken.
// the result sits in an output register, so new items are accepted while it waits.
// if the receiver stalls with a result still held, a finished query waits
//   in its last step and in_tready stays low until the register is free.
// reset: synchronous on rst_n, filter_size returns to 3, no result pending;
//   the stores are not cleared, an entry must be written before it is used.
module zero_padded_2d_correlation_top
  import zpcorr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // row[6:0], col[13:7], pixel[21:14], tap_row[24:22], tap_col[27:25],
  // coefficient[43:28], zero[47:44]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // command[1:0]
  input  logic [CMD_W-1:0]       in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // window_sum[31:0], out_row[38:32], out_col[45:39], zero[47:46]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SIZE_W-1:0]      cfg_data
);

  logic [IMG_AW-1:0]        row_w, col_w;
  logic [PIX_W-1:0]         pixel_w;
  logic [TAP_IDX_W-1:0]     tap_row_w, tap_col_w;
  logic [COEF_W-1:0]        coef_w;
  cmd_t                     cmd_w;

  state_t                   state_r, state_nxt;
  logic [SIZE_W-1:0]        size_r;
  logic [IMG_AW-1:0]        qrow_r, qcol_r;
  logic [TAP_IDX_W-1:0]     i_r, j_r;
  logic                     in_acc, issue, out_free, out_load, last_tap, in_rng;
  logic [SIZE_W-1:0]        n_m1, half;
  logic [CRD_W-1:0]         p_w, q_w;

  logic [PIX_W-1:0]         img_mem [IMG_DEPTH];
  logic [COEF_W-1:0]        tap_mem [FILT_DEPTH];
  logic [PIX_W-1:0]         pix_q_r;
  logic [COEF_W-1:0]        tap_q_r;
  logic                     s1_vld_r, s1_in_r, s1_last_r;
  logic                     s2_vld_r, s2_last_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     out_vld_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;

  assign row_w     = in_tdata[6:0];
  assign col_w     = in_tdata[13:7];
  assign pixel_w   = in_tdata[21:14];
  assign tap_row_w = in_tdata[24:22];
  assign tap_col_w = in_tdata[27:25];
  assign coef_w    = in_tdata[43:28];
  assign cmd_w     = cmd_t'(in_tuser);

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_vld_r || out_tready;
  assign n_m1     = size_r - SIZE_W'(1);
  assign half     = size_r >> 1;
  assign last_tap = (i_r == n_m1) && (j_r == n_m1);

  // window coordinate, negative or past the edge means zero padding
  assign p_w    = CRD_W'(qrow_r) - CRD_W'(half) + CRD_W'(i_r);
  assign q_w    = CRD_W'(qcol_r) - CRD_W'(half) + CRD_W'(j_r);
  assign in_rng = (p_w[CRD_W-1:IMG_AW] == '0) && (q_w[CRD_W-1:IMG_AW] == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && cmd_w == CMD_QUERY) begin
          state_nxt = (size_r == '0) ? ST_DONE : ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (s2_vld_r && s2_last_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_ISSUE: issue     = 1'b1;
      ST_DRAIN: ;
      ST_DONE:  out_load  = out_free;
      default:  ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      size_r    <= SIZE_RESET;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // store writes
  always_ff @(posedge clk) begin
    if (in_acc && cmd_w == CMD_PIXEL) begin
      img_mem[{row_w, col_w}] <= pixel_w;
    end
    if (in_acc && cmd_w == CMD_TAP && tap_row_w < MAX_FILTER && tap_col_w < MAX_FILTER) begin
      tap_mem[FILT_AW'(tap_row_w * MAX_FILTER + tap_col_w)] <= coef_w;
    end
  end

  // store reads, one tap per cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      pix_q_r <= img_mem[{p_w[IMG_AW-1:0], q_w[IMG_AW-1:0]}];
      tap_q_r <= tap_mem[FILT_AW'(i_r * MAX_FILTER + j_r)];
    end
  end

  // window walk and multiply-accumulate
  always_ff @(posedge clk) begin
    s1_in_r   <= in_rng;
    s1_last_r <= last_tap;
    s2_last_r <= s1_vld_r && s1_last_r;
    prod_r    <= s1_in_r ? $signed(tap_q_r) * $signed({1'b0, pix_q_r}) : $signed(PROD_W'(0));
    if (in_acc && cmd_w == CMD_QUERY) begin
      qrow_r <= row_w;
      qcol_r <= col_w;
      i_r    <= '0;
      j_r    <= '0;
      acc_r  <= '0;
    end else begin
      if (issue) begin
        if (j_r == n_m1) begin
          j_r <= '0;
          i_r <= i_r + TAP_IDX_W'(1);
        end else begin
          j_r <= j_r + TAP_IDX_W'(1);
        end
      end
      if (s2_vld_r) begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    if (out_load) begin
      out_data_r <= {2'b00, qcol_r, qrow_r, acc_r};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

// File: src/zpcorr_checker.sv
// port-level checks for the zero-padded 2d correlation block, bound to the top level
module zpcorr_checker
  import zpcorr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [CMD_W-1:0]       in_tuser,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result item present after reset");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_QUERY |=> !in_tready)
    else $error("new item taken while a query is in progress");

  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser != CMD_QUERY |=> in_tready)
    else $error("load item stalled the input");

endmodule

bind zero_padded_2d_correlation_top zpcorr_checker u_zpcorr_checker (.*);
